>>> sv/vscd_pkg.sv
// Package for the video start-code codec detector: codes, header constants and verdict function.
package vscd_pkg;

  localparam int DEFAULT_MAX_BUFFER_BYTES = 65536;
  localparam int POS_W = 16;
  localparam int MIN_BUFFER_BYTES = 6;

  localparam logic [1:0] CODEC_NONE = 2'd0;
  localparam logic [1:0] CODEC_HEVC = 2'd1;
  localparam logic [1:0] CODEC_AVC  = 2'd2;
  localparam logic [1:0] CODEC_MPEG = 2'd3;

  localparam logic [7:0] MPEG_SEQ_HDR = 8'hB3;
  localparam logic [7:0] MPEG_EXT     = 8'hB5;
  localparam logic [7:0] MPEG_GOP     = 8'hB8;

  localparam logic [5:0] HEVC_VPS      = 6'd32;
  localparam logic [5:0] HEVC_SPS      = 6'd33;
  localparam logic [5:0] HEVC_PPS      = 6'd34;
  localparam logic [5:0] HEVC_IDR_W    = 6'd19;
  localparam logic [5:0] HEVC_IDR_N    = 6'd20;
  localparam logic [5:0] HEVC_CRA      = 6'd21;

  localparam logic [4:0] AVC_SPS = 5'd7;
  localparam logic [4:0] AVC_PPS = 5'd8;
  localparam logic [4:0] AVC_IDR = 5'd5;

  function automatic logic [1:0] verdict(
    input logic [2:0]       mpeg_seen,
    input logic [3:0]       hevc_seen,
    input logic [2:0]       hevc_hits,
    input logic [2:0]       avc_hits,
    input logic [POS_W-1:0] hevc_last_pos,
    input logic [POS_W-1:0] avc_last_pos
  );
    logic       mpeg_ok;
    logic       hevc_ok;
    logic       avc_ok;
    logic [1:0] ps_cnt;
    logic [1:0] res;
    mpeg_ok = mpeg_seen[0] && (mpeg_seen[2:1] != 2'b00);
    ps_cnt  = {1'b0, hevc_seen[0]} + {1'b0, hevc_seen[1]} + {1'b0, hevc_seen[2]};
    hevc_ok = (hevc_hits >= 3'd2) && (hevc_seen[0] || ps_cnt >= 2'd2);
    avc_ok  = avc_hits >= 3'd2;
    if (mpeg_ok) begin
      res = CODEC_MPEG;
    end else if (hevc_ok && avc_ok) begin
      if (avc_hits > hevc_hits ||
          (avc_hits == hevc_hits && avc_last_pos > hevc_last_pos)) begin
        res = CODEC_AVC;
      end else begin
        res = CODEC_HEVC;
      end
    end else if (hevc_ok) begin
      res = CODEC_HEVC;
    end else if (avc_ok) begin
      res = CODEC_AVC;
    end else begin
      res = CODEC_NONE;
    end
    return res;
  endfunction

endpackage

>>> sv/video_start_code_codec_detect.sv
// Start-code scanner that detects MPEG-2, H.264 or HEVC video in one buffer.
// The verdict is loaded into the output register as the last byte is taken.
// Throughput: one byte per cycle while s_tready is high; evidence state updates in the accepting cycle.
// A verdict waiting on m_tready holds s_tready low; a request is taken in the cycle it drains.
// Reset (rst, synchronous) clears the scan state and empties the output register.
module video_start_code_codec_detect
  import vscd_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = DEFAULT_MAX_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] codec, [7:2] zero
);

  localparam int POS_CAP_INT = (MAX_BUFFER_BYTES - 1 > (1 << POS_W) - 1) ?
                               (1 << POS_W) - 1 : MAX_BUFFER_BYTES - 1;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

  logic [31:0]      byte_history, byte_history_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [2:0]       mpeg_seen, mpeg_seen_next;
  logic [3:0]       hevc_seen, hevc_seen_next;
  logic [2:0]       avc_seen, avc_seen_next;
  logic [2:0]       mpeg_hits, mpeg_hits_next;
  logic [2:0]       hevc_hits, hevc_hits_next;
  logic [2:0]       avc_hits, avc_hits_next;
  logic [POS_W-1:0] hevc_last_pos, hevc_last_pos_next;
  logic [POS_W-1:0] avc_last_pos, avc_last_pos_next;
  logic [POS_W-1:0] mpeg_last_pos, mpeg_last_pos_next;
  logic             frozen, frozen_next;
  logic [1:0]       codec, codec_next;

  logic             accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {6'b0, codec};

  always_comb begin
    logic [7:0]       c;
    logic [7:0]       b0;
    logic [5:0]       kind;
    logic [4:0]       akind;
    logic [3:0]       hbit;
    logic [2:0]       mbit;
    logic [2:0]       abit;
    logic [POS_W-1:0] pos4;
    logic [POS_W-1:0] pos3;
    c    = s_tdata;
    b0   = byte_history[7:0];
    kind = b0[6:1];
    akind = c[4:0];
    hbit = 4'b0;
    mbit = 3'b0;
    abit = 3'b0;
    pos4 = (byte_position >= POS_W'(4)) ? byte_position - POS_W'(4) : '0;
    pos3 = (byte_position >= POS_W'(3)) ? byte_position - POS_W'(3) : '0;

    mpeg_seen_next     = mpeg_seen;
    hevc_seen_next     = hevc_seen;
    avc_seen_next      = avc_seen;
    mpeg_hits_next     = mpeg_hits;
    hevc_hits_next     = hevc_hits;
    avc_hits_next      = avc_hits;
    mpeg_last_pos_next = mpeg_last_pos;
    hevc_last_pos_next = hevc_last_pos;
    avc_last_pos_next  = avc_last_pos;
    frozen_next        = frozen;

    if (!frozen) begin
      // HEVC: header byte was the previous byte, c is the second header byte
      if (byte_history[31:8] == 24'h000001 && !b0[7] && c[2:0] != 3'b0 &&
          !b0[0] && c[7:3] == 5'b0) begin
        if (kind == HEVC_VPS) begin
          hbit = 4'b0001;
        end else if (kind == HEVC_SPS) begin
          hbit = 4'b0010;
        end else if (kind == HEVC_PPS) begin
          hbit = 4'b0100;
        end else if ((kind == HEVC_IDR_W || kind == HEVC_IDR_N || kind == HEVC_CRA) &&
                     hevc_seen[2:0] != 3'b0) begin
          hbit = 4'b1000;
        end
        if (hbit != 4'b0) begin
          if ((hevc_seen & hbit) == 4'b0) begin
            hevc_seen_next = hevc_seen | hbit;
            hevc_hits_next = hevc_hits + 3'd1;
          end
          hevc_last_pos_next = pos4;
        end
      end
      // MPEG-2 and H.264: c is the header byte
      if (byte_history[23:0] == 24'h000001) begin
        if (c == MPEG_SEQ_HDR) begin
          mbit = 3'b001;
        end else if (c == MPEG_EXT) begin
          mbit = 3'b010;
        end else if (c == MPEG_GOP) begin
          mbit = 3'b100;
        end
        if (mbit != 3'b0) begin
          if ((mpeg_seen & mbit) == 3'b0) begin
            mpeg_seen_next = mpeg_seen | mbit;
            mpeg_hits_next = mpeg_hits + 3'd1;
          end
          mpeg_last_pos_next = pos3;
          if (mpeg_seen_next[0] && mpeg_seen_next[2:1] != 2'b00) begin
            frozen_next = 1'b1;
          end
        end
        if (!frozen_next && !c[7] && c[6:5] != 2'b00) begin
          if (akind == AVC_SPS) begin
            abit = 3'b001;
          end else if (akind == AVC_PPS) begin
            abit = 3'b010;
          end else if (akind == AVC_IDR) begin
            abit = 3'b100;
          end
          if (abit != 3'b0) begin
            if ((avc_seen & abit) == 3'b0) begin
              avc_seen_next = avc_seen | abit;
              avc_hits_next = avc_hits + 3'd1;
            end
            avc_last_pos_next = pos3;
          end
        end
      end
    end

    byte_history_next  = {byte_history[23:0], c};
    byte_position_next = (byte_position < POS_CAP) ? byte_position + POS_W'(1) :
                                                     byte_position;

    if (byte_position < POS_W'(MIN_BUFFER_BYTES - 1)) begin
      codec_next = CODEC_NONE;
    end else begin
      codec_next = verdict(mpeg_seen_next, hevc_seen_next, hevc_hits_next,
                           avc_hits_next, hevc_last_pos_next, avc_last_pos_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      byte_history  <= 32'hFFFF_FFFF;
      byte_position <= '0;
      mpeg_seen     <= '0;
      hevc_seen     <= '0;
      avc_seen      <= '0;
      mpeg_hits     <= '0;
      hevc_hits     <= '0;
      avc_hits      <= '0;
      mpeg_last_pos <= '0;
      hevc_last_pos <= '0;
      avc_last_pos  <= '0;
      frozen        <= 1'b0;
    end else if (accept) begin
      byte_history  <= byte_history_next;
      byte_position <= byte_position_next;
      mpeg_seen     <= mpeg_seen_next;
      hevc_seen     <= hevc_seen_next;
      avc_seen      <= avc_seen_next;
      mpeg_hits     <= mpeg_hits_next;
      hevc_hits     <= hevc_hits_next;
      avc_hits      <= avc_hits_next;
      mpeg_last_pos <= mpeg_last_pos_next;
      hevc_last_pos <= hevc_last_pos_next;
      avc_last_pos  <= avc_last_pos_next;
      frozen        <= frozen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      codec <= codec_next;
    end
  end

endmodule

>>> dv/video_start_code_codec_detect_tb.sv
// Testbench for the start-code codec detector: byte stimulus, verdict prediction and checking.
`timescale 1ns / 100ps

module video_start_code_codec_detect_tb
  import vscd_pkg::*;
();

  class codec_verdict_board;
    logic [31:0] hist;
    int unsigned count;
    int unsigned cap;
    logic [3:0]  mpeg_mask, hevc_mask, avc_mask;
    logic [2:0]  mpeg_n, hevc_n, avc_n;
    logic [15:0] mpeg_at, hevc_at, avc_at;
    bit          locked;
    logic [1:0]  due_codec[$];
    int          errors;
    int          verdicts;
    int          per_codec[4];

    function new(int max_bytes);
      cap = (max_bytes - 1 > 'hFFFF) ? 'hFFFF : max_bytes - 1;
      errors = 0;
      verdicts = 0;
      foreach (per_codec[i]) per_codec[i] = 0;
      clear();
    endfunction

    function void clear();
      hist = 32'hFFFF_FFFF;
      count = 0;
      mpeg_mask = '0; hevc_mask = '0; avc_mask = '0;
      mpeg_n = '0; hevc_n = '0; avc_n = '0;
      mpeg_at = '0; hevc_at = '0; avc_at = '0;
      locked = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void add_hit(inout logic [3:0] mask, inout logic [2:0] n,
                          inout logic [15:0] at,
                          input logic [3:0] b, input logic [15:0] p);
      if ((mask & b) == 4'd0) begin
        mask |= b;
        n++;
      end
      at = p;
    endfunction

    function logic [1:0] decide();
      bit m_ok, h_ok, a_ok;
      int ps;
      m_ok = mpeg_mask[0] && (mpeg_mask[2:1] != 2'b00);
      ps = hevc_mask[0] + hevc_mask[1] + hevc_mask[2];
      h_ok = (hevc_n >= 3'd2) && (hevc_mask[0] || ps >= 2);
      a_ok = avc_n >= 3'd2;
      if (m_ok) return CODEC_MPEG;
      if (h_ok && a_ok)
        return (avc_n > hevc_n || (avc_n == hevc_n && avc_at > hevc_at)) ?
               CODEC_AVC : CODEC_HEVC;
      if (h_ok) return CODEC_HEVC;
      if (a_ok) return CODEC_AVC;
      return CODEC_NONE;
    endfunction

    // Note one accepted request; on the last byte queue the expected verdict.
    function void take_byte(logic [7:0] c, logic l);
      logic [7:0]  b0;
      logic [5:0]  kind;
      logic [3:0]  b;
      logic [15:0] at;
      logic [1:0]  v;
      int unsigned prior_count;
      if (!locked) begin
        if (hist[31:8] == 24'h000001) begin
          b0 = hist[7:0];
          at = (count >= 4) ? 16'(count - 4) : 16'd0;
          if (!b0[7] && c[2:0] != 3'd0 && !b0[0] && c[7:3] == 5'd0) begin
            kind = b0[6:1];
            b = 4'd0;
            if (kind == HEVC_VPS) b = 4'd1;
            else if (kind == HEVC_SPS) b = 4'd2;
            else if (kind == HEVC_PPS) b = 4'd4;
            else if ((kind == HEVC_IDR_W || kind == HEVC_IDR_N || kind == HEVC_CRA) &&
                     hevc_mask[2:0] != 3'd0) b = 4'd8;
            if (b != 4'd0) add_hit(hevc_mask, hevc_n, hevc_at, b, at);
          end
        end
        if (hist[23:0] == 24'h000001) begin
          at = (count >= 3) ? 16'(count - 3) : 16'd0;
          b = 4'd0;
          if (c == MPEG_SEQ_HDR) b = 4'd1;
          else if (c == MPEG_EXT) b = 4'd2;
          else if (c == MPEG_GOP) b = 4'd4;
          if (b != 4'd0) begin
            add_hit(mpeg_mask, mpeg_n, mpeg_at, b, at);
            if (mpeg_mask[0] && mpeg_mask[2:1] != 2'b00) locked = 1'b1;
          end
          if (!locked && !c[7] && c[6:5] != 2'b00) begin
            b = 4'd0;
            if (c[4:0] == AVC_SPS) b = 4'd1;
            else if (c[4:0] == AVC_PPS) b = 4'd2;
            else if (c[4:0] == AVC_IDR) b = 4'd4;
            if (b != 4'd0) add_hit(avc_mask, avc_n, avc_at, b, at);
          end
        end
      end
      hist = {hist[23:0], c};
      prior_count = count;
      if (count < cap) count++;
      if (l) begin
        v = (prior_count + 1 < MIN_BUFFER_BYTES) ? CODEC_NONE : decide();
        due_codec.push_back(v);
        per_codec[v]++;
        clear();
      end
    endfunction

    task check_verdict(logic [7:0] d);
      logic [1:0] exp_codec;
      verdicts++;
      if (due_codec.size() == 0) begin
        report($sformatf("verdict %0d with no buffer pending", d[1:0]));
        return;
      end
      exp_codec = due_codec.pop_front();
      if (d[1:0] != exp_codec)
        report($sformatf("codec %0d, expected %0d", d[1:0], exp_codec));
      if (d[7:2] != 6'd0)
        report($sformatf("pad bits 0x%0h not zero", d[7:2]));
    endtask
  endclass

  localparam int MAX_BYTES = DEFAULT_MAX_BUFFER_BYTES;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] data_byte
  logic       s_tlast = 1'b0;   // last_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [1:0] codec, [7:2] zero

  codec_verdict_board board;
  logic [7:0] bytes_q[$];
  bit         idle_on = 1'b1;
  int         sent = 0;
  int         buffers = 0;

  video_start_code_codec_detect #(
    .MAX_BUFFER_BYTES(MAX_BYTES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    board.take_byte(d, l);
    sent++;
  endtask

  task automatic send_buf();
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
    bytes_q.delete();
    buffers++;
  endtask

  function automatic void push_code(bit broken);
    if (!broken) begin
      bytes_q.push_back(8'h00); bytes_q.push_back(8'h00); bytes_q.push_back(8'h01);
    end else if ($urandom_range(0, 1) == 0) begin
      bytes_q.push_back(8'h00); bytes_q.push_back(8'h01);
    end else begin
      bytes_q.push_back(8'h00); bytes_q.push_back(8'h00); bytes_q.push_back(8'h02);
    end
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'h01;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] mpeg_hdr();
    case ($urandom_range(0, 4))
      0, 3:    return MPEG_SEQ_HDR;
      1:       return MPEG_EXT;
      2:       return MPEG_GOP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] avc_hdr();
    logic [4:0] t;
    logic [1:0] nri;
    logic       fb;
    case ($urandom_range(0, 5))
      0:       t = AVC_SPS;
      1:       t = AVC_PPS;
      2:       t = AVC_IDR;
      3:       t = 5'd1;
      default: t = 5'($urandom_range(0, 31));
    endcase
    nri = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    fb  = ($urandom_range(0, 15) == 0);
    return {fb, nri, t};
  endfunction

  function automatic void push_hevc();
    logic [5:0] t;
    logic [5:0] layer;
    logic [2:0] tid;
    logic       fb;
    case ($urandom_range(0, 7))
      0:       t = HEVC_VPS;
      1:       t = HEVC_SPS;
      2:       t = HEVC_PPS;
      3:       t = HEVC_IDR_W;
      4:       t = HEVC_IDR_N;
      5:       t = HEVC_CRA;
      6:       t = 6'd1;
      default: t = 6'($urandom_range(0, 63));
    endcase
    layer = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(1, 63)) : 6'd0;
    tid   = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    fb    = ($urandom_range(0, 15) == 0);
    bytes_q.push_back({fb, t, layer[5]});
    bytes_q.push_back({layer[4:0], tid});
  endfunction

  // Mostly streams of start codes with headers of one flavor or a mix, some noise and broken codes.
  function automatic void gen_buffer();
    int shape, flav, units, k;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 24)) bytes_q.push_back(noise_byte());
    end else if (shape == 1) begin
      repeat ($urandom_range(1, 5)) bytes_q.push_back(noise_byte());
    end else begin
      flav  = $urandom_range(0, 4);
      units = $urandom_range(1, 6);
      repeat ($urandom_range(0, 3)) bytes_q.push_back(noise_byte());
      repeat (units) begin
        push_code($urandom_range(0, 9) == 0);
        k = (flav == 4) ? $urandom_range(0, 2) : (flav == 3) ? $urandom_range(1, 2) : flav;
        case (k)
          0:       bytes_q.push_back(mpeg_hdr());
          1:       bytes_q.push_back(avc_hdr());
          default: push_hevc();
        endcase
        repeat ($urandom_range(0, 4)) bytes_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic run_directed();
    bytes_q = '{8'hFF};
    send_buf();
    bytes_q = '{8'h00, 8'h00, 8'h01, 8'hB3, 8'hB5};
    send_buf();
    // sequence + extension freezes; later H.264 headers are ignored
    bytes_q = '{8'h00, 8'h00, 8'h01, 8'hB3, 8'h12, 8'h00, 8'h00, 8'h01, 8'hB5, 8'h34,
                8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68};
    send_buf();
    bytes_q = '{8'h00, 8'h00, 8'h01, 8'hB8, 8'h00, 8'h00, 8'h01, 8'hB3, 8'hFF};
    send_buf();
    bytes_q = '{8'h00, 8'h00, 8'h01, 8'h67, 8'hAA, 8'h00, 8'h00, 8'h01, 8'h68, 8'hBB,
                8'h00, 8'h00, 8'h01, 8'h65};
    send_buf();
    // IDR before any parameter set does not count
    bytes_q = '{8'h00, 8'h00, 8'h01, 8'h26, 8'h01, 8'h00, 8'h00, 8'h01, 8'h40, 8'h01,
                8'h00, 8'h00, 8'h01, 8'h42, 8'h01, 8'h00, 8'h00, 8'h01, 8'h44, 8'h01,
                8'h00, 8'h00, 8'h01, 8'h26, 8'h01};
    send_buf();
    // header on the last byte: no HEVC evidence, H.264 still counts
    bytes_q = '{8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h01, 8'h67,
                8'h00, 8'h00, 8'h01, 8'h68, 8'h00, 8'h00, 8'h01, 8'h42};
    send_buf();
    // tie on hits, H.264 later
    bytes_q = '{8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h01, 8'h42, 8'h01,
                8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68, 8'h80};
    send_buf();
    bytes_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_buf();
    bytes_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buf();
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_verdict(m_tdata);
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int  rand_start;
    int  guard;
    board = new(MAX_BYTES);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    rand_start = sent;
    while (sent - rand_start < 830) begin
      gen_buffer();
      if (sent - rand_start > 700) idle_on = 1'b0;
      send_buf();
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    guard = 0;
    while (board.due_codec.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (board.due_codec.size() != 0)
      board.report($sformatf("%0d verdicts never arrived", board.due_codec.size()));
    $display("Ran %0d buffers, %0d bytes, incl. short, frozen and stall-free tail buffers",
             buffers, sent);
    $display("Verdicts checked %0d: none %0d, HEVC %0d, H.264 %0d, MPEG-2 %0d",
             board.verdicts, board.per_codec[CODEC_NONE], board.per_codec[CODEC_HEVC],
             board.per_codec[CODEC_AVC], board.per_codec[CODEC_MPEG]);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
